### src/owsm_pkg.sv
// ----------------------------------------------------------------------------
// owsm_pkg
// Shared types and constants of the omni-wheel speed mixer.
// ----------------------------------------------------------------------------
package owsm_pkg;

  // Q8.8 velocity, Q16.16 gain, Q24.24 product, int16 speed
  typedef logic signed [15:0] vel_t;
  typedef logic signed [31:0] gain_t;
  typedef logic signed [47:0] prod_t;
  typedef logic signed [15:0] speed_t;
  typedef logic        [15:0] decay_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_FRONT_SINE   = 3'd0;
  localparam cfg_idx_t REG_FRONT_COSINE = 3'd1;
  localparam cfg_idx_t REG_BACK_SINE    = 3'd2;
  localparam cfg_idx_t REG_BACK_COSINE  = 3'd3;
  localparam cfg_idx_t REG_SPIN         = 3'd4;
  localparam cfg_idx_t REG_DECAY        = 3'd5;

  localparam decay_t DECAY_RESET = 16'd26214;

  localparam speed_t SPEED_MAX = 16'sh7FFF;
  localparam speed_t SPEED_MIN = -16'sh8000;

  typedef struct packed {
    gain_t  front_sine;
    gain_t  front_cosine;
    gain_t  back_sine;
    gain_t  back_cosine;
    gain_t  spin;
    decay_t decay;
  } owsm_gains_t;

  typedef struct packed {
    vel_t u;
    vel_t v;
    vel_t w;
  } owsm_vel_t;

  typedef struct packed {
    prod_t u_front;
    prod_t v_front;
    prod_t u_back;
    prod_t v_back;
    prod_t w_spin;
  } owsm_prod_t;

endpackage

### src/owsm_ifs.sv
// ----------------------------------------------------------------------------
// owsm channel interfaces
// Command, speed and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface owsm_cmd_if;
  logic           valid;
  logic           ready;
  logic           action;
  owsm_pkg::vel_t vel_u_in;
  owsm_pkg::vel_t vel_v_in;
  owsm_pkg::vel_t vel_w_in;

  modport source (output valid, output action, output vel_u_in, output vel_v_in,
                  output vel_w_in, input ready);
  modport sink (input valid, input action, input vel_u_in, input vel_v_in,
                input vel_w_in, output ready);
endinterface

interface owsm_spd_if;
  logic             valid;
  logic             ready;
  owsm_pkg::speed_t front_right_speed;
  owsm_pkg::speed_t back_right_speed;
  owsm_pkg::speed_t back_left_speed;
  owsm_pkg::speed_t front_left_speed;
  logic             saturated;

  modport source (output valid, output front_right_speed, output back_right_speed,
                  output back_left_speed, output front_left_speed, output saturated,
                  input ready);
  modport sink (input valid, input front_right_speed, input back_right_speed,
                input back_left_speed, input front_left_speed, input saturated,
                output ready);
endinterface

interface owsm_cfg_if;
  logic                valid;
  logic                ready;
  owsm_pkg::cfg_idx_t  index;
  owsm_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/owsm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owsm_cfg_regs
// Gain and decay registers written through the configuration channel.
// ----------------------------------------------------------------------------
module owsm_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  owsm_pkg::cfg_idx_t    wr_index,
  input  owsm_pkg::cfg_data_t   wr_data,
  output owsm_pkg::owsm_gains_t gains
);
  import owsm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.front_sine   <= '0;
      gains.front_cosine <= '0;
      gains.back_sine    <= '0;
      gains.back_cosine  <= '0;
      gains.spin         <= '0;
      gains.decay        <= DECAY_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_FRONT_SINE:   gains.front_sine   <= gain_t'(wr_data);
        REG_FRONT_COSINE: gains.front_cosine <= gain_t'(wr_data);
        REG_BACK_SINE:    gains.back_sine    <= gain_t'(wr_data);
        REG_BACK_COSINE:  gains.back_cosine  <= gain_t'(wr_data);
        REG_SPIN:         gains.spin         <= gain_t'(wr_data);
        REG_DECAY:        gains.decay        <= wr_data[15:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

endmodule

### src/owsm_vel_hold.sv
// ----------------------------------------------------------------------------
// owsm_vel_hold
// Held velocity with per-beat decay of u and v (w is held as is), and the input register of the pipe.
// ----------------------------------------------------------------------------
module owsm_vel_hold (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  owsm_pkg::vel_t      vel_u_in,
  input  owsm_pkg::vel_t      vel_v_in,
  input  owsm_pkg::vel_t      vel_w_in,
  input  owsm_pkg::decay_t    decay,
  output logic                out_valid,
  input  logic                out_ready,
  output owsm_pkg::owsm_vel_t vel
);
  import owsm_pkg::*;

  vel_t              held_u;
  vel_t              held_v;
  vel_t              held_w;
  owsm_vel_t         used;
  logic signed [32:0] prod_u;
  logic signed [32:0] prod_v;
  logic signed [32:0] rnd_u;
  logic signed [32:0] rnd_v;
  vel_t              held_u_next;
  vel_t              held_v_next;
  logic              accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    used.u = action ? vel_u_in : held_u;
    used.v = action ? vel_v_in : held_v;
    used.w = action ? vel_w_in : held_w;
  end

  // decay: x * d / 2^16, half away from zero
  assign prod_u = used.u * $signed({1'b0, decay});
  assign prod_v = used.v * $signed({1'b0, decay});
  assign rnd_u  = prod_u + (prod_u[32] ? 33'sd32767 : 33'sd32768);
  assign rnd_v  = prod_v + (prod_v[32] ? 33'sd32767 : 33'sd32768);
  assign held_u_next = rnd_u[31:16];
  assign held_v_next = rnd_v[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      held_u    <= '0;
      held_v    <= '0;
      held_w    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        held_u <= held_u_next;
        held_v <= held_v_next;
        held_w <= used.w;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vel <= used;
    end
  end

  a_load_used : assert property (@(posedge clk)
    (!rst && accept && action) |=> (vel.u == $past(vel_u_in) && vel.w == $past(vel_w_in)))
    else $error("loaded velocity not passed to pipe");

  a_held_quiet : assert property (@(posedge clk)
    (!rst && !accept) |=> ($stable(held_u) && $stable(held_v) && $stable(held_w)))
    else $error("held velocity changed without a beat");

endmodule

### src/owsm_mult_stage.sv
// ----------------------------------------------------------------------------
// owsm_mult_stage
// Velocity times gain products, registered ahead of the mixing adders.
// ----------------------------------------------------------------------------
module owsm_mult_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  owsm_pkg::owsm_vel_t   vel,
  input  owsm_pkg::owsm_gains_t gains,
  output logic                  out_valid,
  input  logic                  out_ready,
  output owsm_pkg::owsm_prod_t  prod
);
  import owsm_pkg::*;

  owsm_prod_t prod_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod_next.u_front = vel.u * gains.front_sine;
    prod_next.v_front = vel.v * gains.front_cosine;
    prod_next.u_back  = vel.u * gains.back_sine;
    prod_next.v_back  = vel.v * gains.back_cosine;
    prod_next.w_spin  = vel.w * gains.spin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod <= prod_next;
    end
  end

endmodule

### src/owsm_mix_stage.sv
// ----------------------------------------------------------------------------
// owsm_mix_stage
// Sign-patterned wheel sums, rounding, int16 clamp and the result register.
// ----------------------------------------------------------------------------
module owsm_mix_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  owsm_pkg::owsm_prod_t prod,
  output logic                 out_valid,
  input  logic                 out_ready,
  output owsm_pkg::speed_t     front_right_speed,
  output owsm_pkg::speed_t     back_right_speed,
  output owsm_pkg::speed_t     back_left_speed,
  output owsm_pkg::speed_t     front_left_speed,
  output logic                 saturated
);
  import owsm_pkg::*;

  typedef logic signed [49:0] sum_t;

  localparam sum_t RndHalf = 50'sd8388608;

  // returns {clamped, speed}
  function automatic logic [16:0] to_speed(input sum_t s);
    sum_t               r;
    logic signed [25:0] q;
    logic [16:0]        res;
    r = s + (s[49] ? (RndHalf - 50'sd1) : RndHalf);
    q = r[49:24];
    if (q > 26'sd32767) begin
      res = {1'b1, SPEED_MAX};
    end else if (q < -26'sd32768) begin
      res = {1'b1, SPEED_MIN};
    end else begin
      res = {1'b0, q[15:0]};
    end
    return res;
  endfunction

  sum_t        uf;
  sum_t        vf;
  sum_t        ub;
  sum_t        vb;
  sum_t        ws;
  logic [16:0] fr;
  logic [16:0] br;
  logic [16:0] bl;
  logic [16:0] fl;

  assign in_ready = !out_valid || out_ready;

  assign uf = sum_t'(prod.u_front);
  assign vf = sum_t'(prod.v_front);
  assign ub = sum_t'(prod.u_back);
  assign vb = sum_t'(prod.v_back);
  assign ws = sum_t'(prod.w_spin);

  assign fr = to_speed(ws - uf - vf);
  assign br = to_speed(ws + ub - vb);
  assign bl = to_speed(ws + ub + vb);
  assign fl = to_speed(ws - uf + vf);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      front_right_speed <= fr[15:0];
      back_right_speed  <= br[15:0];
      back_left_speed   <= bl[15:0];
      front_left_speed  <= fl[15:0];
      saturated         <= fr[16] | br[16] | bl[16] | fl[16];
    end
  end

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result register valid after reset");

  a_sat_at_rail : assert property (@(posedge clk)
    (out_valid && saturated) |->
      (front_right_speed == SPEED_MAX || front_right_speed == SPEED_MIN ||
       back_right_speed == SPEED_MAX  || back_right_speed == SPEED_MIN  ||
       back_left_speed == SPEED_MAX   || back_left_speed == SPEED_MIN   ||
       front_left_speed == SPEED_MAX  || front_left_speed == SPEED_MIN))
    else $error("saturation flag without a speed at a rail");

endmodule

### src/omni_wheel_speed_mixer_top.sv
// ----------------------------------------------------------------------------
// omni_wheel_speed_mixer_top
// Four-wheel omni-drive mixer: held robot velocity to four motor speeds.
// ----------------------------------------------------------------------------
// usage:
//   cmd carries one command beat: action 1 loads vel_u/v/w_in, action 0
//   reuses the held velocity. every command beat gives exactly one beat on
//   spd with the four wheel speeds and the saturation flag.
//   cfg writes the gain and decay registers by index; it is always ready
//   and is meant to be used while no command is in flight.
//   a result is valid once its command beat has gone through the input
//   register (at the edge that takes it), the product register and then
//   the result register.
//   throughput: one command per cycle while spd is not stalled; the
//   held-velocity decay is a 16x17 multiply per decayed component in the
//   accept cycle and the gain products have their own register stage.
//   when spd is stalled each stage holds its beat; cmd stays ready while
//   any stage in front of the stall is empty.
//   reset clears the held velocity, the gains and all stage valids, and
//   sets the decay factor to about 0.4.
// ----------------------------------------------------------------------------
module omni_wheel_speed_mixer_top (
  input logic   clk,
  input logic   rst,
  owsm_cmd_if.sink   cmd,
  owsm_spd_if.source spd,
  owsm_cfg_if.sink   cfg
);
  import owsm_pkg::*;

  owsm_gains_t gains;
  owsm_vel_t   vel;
  owsm_prod_t  prod;
  logic        vel_valid;
  logic        vel_ready;
  logic        prod_valid;
  logic        prod_ready;

  assign cfg.ready = 1'b1;

  owsm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .gains    (gains)
  );

  owsm_vel_hold u_vel_hold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .action    (cmd.action),
    .vel_u_in  (cmd.vel_u_in),
    .vel_v_in  (cmd.vel_v_in),
    .vel_w_in  (cmd.vel_w_in),
    .decay     (gains.decay),
    .out_valid (vel_valid),
    .out_ready (vel_ready),
    .vel       (vel)
  );

  owsm_mult_stage u_mult_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vel_valid),
    .in_ready  (vel_ready),
    .vel       (vel),
    .gains     (gains),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .prod      (prod)
  );

  owsm_mix_stage u_mix_stage (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (prod_valid),
    .in_ready          (prod_ready),
    .prod              (prod),
    .out_valid         (spd.valid),
    .out_ready         (spd.ready),
    .front_right_speed (spd.front_right_speed),
    .back_right_speed  (spd.back_right_speed),
    .back_left_speed   (spd.back_left_speed),
    .front_left_speed  (spd.front_left_speed),
    .saturated         (spd.saturated)
  );

endmodule
